// ===== src/tlcs_pkg.sv =====
`default_nettype none
package tlcs_pkg;

  localparam int MAIN_DEPTH_DEF       = 32;
  localparam int HIGH_DEPTH_DEF       = 16;
  localparam int PARAM_BITS           = 10;
  localparam int CREDIT_FRAC_BITS_DEF = 8;

  localparam int CREDIT_W  = 12;
  localparam int CNT_W     = 32;
  localparam int DRAIN_W   = 6;
  localparam int CFG_IDX_W = 1;
  // entry layout below the key: has, port, length, three bytes
  localparam int ENT_FIXED_W = 41;

  localparam logic [CREDIT_W-1:0] BUDGET_RST = 12'd256;
  localparam logic [CREDIT_W-1:0] MAX_CR_RST = 12'd2048;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CR = 1'b1;

  localparam logic [7:0] MAX_MSG_LEN = 8'd3;

  typedef enum logic [2:0] {
    OP_ENQ_MAIN   = 3'd0,
    OP_ENQ_HIGH   = 3'd1,
    OP_ENQ_POS    = 3'd2,
    OP_CANCEL     = 3'd3,
    OP_CANCEL_ALL = 3'd4,
    OP_QUERY      = 3'd5,
    OP_TICK       = 3'd6,
    OP_DRAIN      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_SENT    = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_COAL_RD,
    S_COAL_EV,
    S_FILT_RD,
    S_FILT_EV,
    S_QRY_RD,
    S_QRY_EV,
    S_APPEND,
    S_POP_CHK,
    S_POP_EV,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic latch;
    logic j_load_fill;
    logic j_clear;
    logic j_dec;
    logic rd_back;
    logic rd_fwd;
    logic rd_pop;
    logic coal_hit;
    logic filt_eval;
    logic filt_done;
    logic qry_eval;
    logic append;
    logic tick_add;
    logic pop_commit;
    logic emit_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic j_zero;
    logic scan_end;
    logic match;
    logic can_pop;
    logic out_free;
    logic pop_last;
  } status_t;

endpackage
`default_nettype wire

// ===== src/tlcs_if.sv =====
`default_nettype none
interface tlcs_item_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      operation;
  logic [tlcs_pkg::PARAM_BITS-1:0] param_id;
  logic                            has_param;
  logic [7:0]                      out_port;
  logic [7:0]                      msg_length;
  logic [7:0]                      msg_byte0;
  logic [7:0]                      msg_byte1;
  logic [7:0]                      msg_byte2;
  modport source (output valid, operation, param_id, has_param, out_port, msg_length,
                  msg_byte0, msg_byte1, msg_byte2, input ready);
  modport sink (input valid, operation, param_id, has_param, out_port, msg_length,
                msg_byte0, msg_byte1, msg_byte2, output ready);
endinterface

interface tlcs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  sent_port;
  logic [7:0]  sent_length;
  logic [7:0]  sent_byte0;
  logic [7:0]  sent_byte1;
  logic [7:0]  sent_byte2;
  logic        pending_flag;
  logic        last_flag;
  logic [5:0]  drained_count;
  logic [31:0] sent_total;
  logic [31:0] dropped_total;
  logic [31:0] coalesced_total;
  modport source (output valid, result_kind, sent_port, sent_length, sent_byte0, sent_byte1,
                  sent_byte2, pending_flag, last_flag, drained_count, sent_total,
                  dropped_total, coalesced_total, input ready);
  modport sink (input valid, result_kind, sent_port, sent_length, sent_byte0, sent_byte1,
                sent_byte2, pending_flag, last_flag, drained_count, sent_total,
                dropped_total, coalesced_total, output ready);
endinterface

interface tlcs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/tlcs_ram.sv =====
`default_nettype none
module tlcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/tlcs_ctrl.sv =====
`default_nettype none
module tlcs_ctrl import tlcs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ENQ_MAIN, OP_ENQ_HIGH: state_next = S_APPEND;
          OP_ENQ_POS: begin
            cmd.j_load_fill = 1'b1;
            state_next      = S_COAL_RD;
          end
          OP_CANCEL, OP_CANCEL_ALL: begin
            cmd.j_clear = 1'b1;
            state_next  = S_FILT_RD;
          end
          OP_QUERY: begin
            cmd.j_clear = 1'b1;
            state_next  = S_QRY_RD;
          end
          OP_TICK: begin
            cmd.tick_add = 1'b1;
            state_next   = S_POP_CHK;
          end
          OP_DRAIN: state_next = S_POP_CHK;
          default: state_next = S_IDLE;
        endcase
      end
      // walk back from the newest main entry for the latest match
      S_COAL_RD: begin
        if (sts.j_zero) begin
          state_next = S_APPEND;
        end else begin
          cmd.rd_back = 1'b1;
          state_next  = S_COAL_EV;
        end
      end
      S_COAL_EV: begin
        if (sts.match) begin
          cmd.coal_hit = 1'b1;
          cmd.j_clear  = 1'b1;
          state_next   = S_FILT_RD;
        end else begin
          cmd.j_dec  = 1'b1;
          state_next = S_COAL_RD;
        end
      end
      // compact the main lane, dropping hits
      S_FILT_RD: begin
        if (sts.scan_end) begin
          cmd.filt_done = 1'b1;
          state_next    = (sts.op == OP_ENQ_POS) ? S_APPEND : S_STATUS;
        end else begin
          cmd.rd_fwd = 1'b1;
          state_next = S_FILT_EV;
        end
      end
      S_FILT_EV: begin
        cmd.filt_eval = 1'b1;
        state_next    = S_FILT_RD;
      end
      S_QRY_RD: begin
        if (sts.scan_end) begin
          state_next = S_STATUS;
        end else begin
          cmd.rd_fwd = 1'b1;
          state_next = S_QRY_EV;
        end
      end
      S_QRY_EV: begin
        cmd.qry_eval = 1'b1;
        state_next   = S_QRY_RD;
      end
      S_APPEND: begin
        if (sts.out_free) begin
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP_CHK: begin
        if (sts.can_pop) begin
          cmd.rd_pop = 1'b1;
          state_next = S_POP_EV;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_POP_EV: begin
        if (sts.out_free) begin
          cmd.pop_commit = 1'b1;
          state_next     = sts.pop_last ? S_IDLE : S_POP_CHK;
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |-> state == S_IDLE)
    else $error("item latched outside idle");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.append || cmd.pop_commit || cmd.emit_status) |-> sts.out_free)
    else $error("result emitted into a full output register");
  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_pop |=> state == S_POP_EV)
    else $error("pop read not followed by commit stage");
endmodule
`default_nettype wire

// ===== src/tlcs_datapath.sv =====
`default_nettype none
module tlcs_datapath import tlcs_pkg::*; #(
  parameter int MAIN_DEPTH       = MAIN_DEPTH_DEF,
  parameter int HIGH_DEPTH       = HIGH_DEPTH_DEF,
  parameter int CREDIT_FRAC_BITS = CREDIT_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    sts,
  input  wire logic [2:0]            in_operation,
  input  wire logic [PARAM_BITS-1:0] in_param_id,
  input  wire logic                  in_has_param,
  input  wire logic [7:0]            in_out_port,
  input  wire logic [7:0]            in_msg_length,
  input  wire logic [7:0]            in_msg_byte0,
  input  wire logic [7:0]            in_msg_byte1,
  input  wire logic [7:0]            in_msg_byte2,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CREDIT_W-1:0]   cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_port,
  output logic [7:0]                 out_length,
  output logic [7:0]                 out_byte0,
  output logic [7:0]                 out_byte1,
  output logic [7:0]                 out_byte2,
  output logic                       out_pending,
  output logic                       out_last,
  output logic [DRAIN_W-1:0]         out_drained,
  output logic [CNT_W-1:0]           out_sent,
  output logic [CNT_W-1:0]           out_dropped,
  output logic [CNT_W-1:0]           out_coalesced
);
  localparam int MIDX_W = $clog2(MAIN_DEPTH);
  localparam int MCNT_W = $clog2(MAIN_DEPTH + 1);
  localparam int HIDX_W = $clog2(HIGH_DEPTH);
  localparam int HCNT_W = $clog2(HIGH_DEPTH + 1);
  localparam int ENT_W  = PARAM_BITS + ENT_FIXED_W;
  localparam int HAS_B  = 40;
  localparam logic [MCNT_W-1:0]   MAIN_FULL = MCNT_W'(MAIN_DEPTH);
  localparam logic [HCNT_W-1:0]   HIGH_FULL = HCNT_W'(HIGH_DEPTH);
  localparam logic [CREDIT_W:0]   ONE = (CREDIT_W + 1)'(1) << CREDIT_FRAC_BITS;

  function automatic logic [MIDX_W-1:0] mphys(input logic [MIDX_W-1:0] head,
                                              input logic [MCNT_W-1:0] idx);
    logic [MCNT_W:0] s;
    s = (MCNT_W + 1)'(head) + (MCNT_W + 1)'(idx);
    if (s >= (MCNT_W + 1)'(MAIN_DEPTH)) begin
      s = s - (MCNT_W + 1)'(MAIN_DEPTH);
    end
    return s[MIDX_W-1:0];
  endfunction

  function automatic logic [HIDX_W-1:0] hphys(input logic [HIDX_W-1:0] head,
                                              input logic [HCNT_W-1:0] idx);
    logic [HCNT_W:0] s;
    s = (HCNT_W + 1)'(head) + (HCNT_W + 1)'(idx);
    if (s >= (HCNT_W + 1)'(HIGH_DEPTH)) begin
      s = s - (HCNT_W + 1)'(HIGH_DEPTH);
    end
    return s[HIDX_W-1:0];
  endfunction

  op_t                   op;
  logic [PARAM_BITS-1:0] key_param;
  logic                  key_has;
  logic [ENT_W-1:0]      item_ent;
  logic [MIDX_W-1:0]     m_head;
  logic [MCNT_W-1:0]     m_fill;
  logic [HIDX_W-1:0]     h_head;
  logic [HCNT_W-1:0]     h_fill;
  logic [CREDIT_W-1:0]   credit, budget, max_cr;
  logic [CNT_W-1:0]      sent, dropped, coal;
  logic [MCNT_W-1:0]     j, w, m_idx;
  logic                  found;
  logic [DRAIN_W-1:0]    drained;
  logic                  pop_hi;

  logic                  m_we, m_re, h_we, h_re;
  logic [MIDX_W-1:0]     m_waddr, m_raddr;
  logic [HIDX_W-1:0]     h_waddr;
  logic [ENT_W-1:0]      m_wdata, m_rdata, h_rdata, pop_ent;
  logic                  match, drop, m_full, h_full, any_pend, rem_after, len_ok;
  logic [CREDIT_W:0]     credit_m1, credit_sum;
  logic [7:0]            p_len;

  assign m_full   = (m_fill == MAIN_FULL);
  assign h_full   = (h_fill == HIGH_FULL);
  assign any_pend = (m_fill != '0) || (h_fill != '0);
  assign match    = (m_rdata[HAS_B] == key_has) && (m_rdata[ENT_W-1 -: PARAM_BITS] == key_param);

  always_comb begin
    unique case (op)
      OP_ENQ_POS:    drop = (j == m_idx);
      OP_CANCEL_ALL: drop = m_rdata[HAS_B];
      default:       drop = match;
    endcase
  end

  assign m_we    = (cmd.append && op != OP_ENQ_HIGH && !m_full) || (cmd.filt_eval && !drop);
  assign m_waddr = cmd.append ? mphys(m_head, m_fill) : mphys(m_head, w);
  assign m_wdata = cmd.append ? item_ent : m_rdata;
  assign m_re    = cmd.rd_back || cmd.rd_fwd || cmd.rd_pop;
  assign m_raddr = cmd.rd_back ? mphys(m_head, j - MCNT_W'(1)) :
                   cmd.rd_fwd  ? mphys(m_head, j) : m_head;
  assign h_we    = cmd.append && op == OP_ENQ_HIGH && !h_full;
  assign h_waddr = hphys(h_head, h_fill);
  assign h_re    = cmd.rd_pop;

  tlcs_ram #(.WIDTH(ENT_W), .DEPTH(MAIN_DEPTH)) u_main_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  tlcs_ram #(.WIDTH(ENT_W), .DEPTH(HIGH_DEPTH)) u_high_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(item_ent),
    .re(h_re), .raddr(h_head), .rdata(h_rdata)
  );

  assign pop_ent    = pop_hi ? h_rdata : m_rdata;
  assign p_len      = pop_ent[31:24];
  assign len_ok     = (p_len != 8'd0) && (p_len <= MAX_MSG_LEN);
  assign credit_m1  = {1'b0, credit} - ONE;
  assign credit_sum = {1'b0, credit} + {1'b0, budget};
  assign rem_after  = pop_hi ? (h_fill > HCNT_W'(1) || m_fill != '0)
                             : (m_fill > MCNT_W'(1) || h_fill != '0);

  always_comb begin
    sts          = '0;
    sts.op       = op;
    sts.j_zero   = (j == '0);
    sts.scan_end = (j == m_fill);
    sts.match    = match;
    sts.can_pop  = any_pend && (op == OP_DRAIN || {1'b0, credit} >= ONE);
    sts.out_free = !out_valid || out_ready;
    sts.pop_last = !(rem_after && (op == OP_DRAIN || credit_m1 >= ONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_head    <= '0;
      m_fill    <= '0;
      h_head    <= '0;
      h_fill    <= '0;
      credit    <= '0;
      budget    <= BUDGET_RST;
      max_cr    <= MAX_CR_RST;
      sent      <= '0;
      dropped   <= '0;
      coal      <= '0;
      j         <= '0;
      w         <= '0;
      found     <= 1'b0;
      drained   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BUDGET) begin
          budget <= cfg_data;
        end else if (cfg_index == CFG_MAX_CR) begin
          max_cr <= cfg_data;
        end
      end
      if (cmd.latch) begin
        op        <= op_t'(in_operation);
        key_has   <= in_has_param;
        key_param <= in_has_param ? in_param_id : '0;
        item_ent  <= {(in_has_param ? in_param_id : {PARAM_BITS{1'b0}}), in_has_param,
                      in_out_port, in_msg_length, in_msg_byte0, in_msg_byte1, in_msg_byte2};
        drained   <= '0;
      end
      if (cmd.j_load_fill) begin
        j <= m_fill;
      end
      if (cmd.j_clear) begin
        j     <= '0;
        w     <= '0;
        found <= 1'b0;
      end
      if (cmd.j_dec) begin
        j <= j - MCNT_W'(1);
      end
      if (cmd.coal_hit) begin
        m_idx <= j - MCNT_W'(1);
      end
      if (cmd.filt_eval) begin
        j <= j + MCNT_W'(1);
        if (drop) begin
          coal <= coal + CNT_W'(1);
        end else begin
          w <= w + MCNT_W'(1);
        end
      end
      if (cmd.filt_done) begin
        m_fill <= w;
      end
      if (cmd.qry_eval) begin
        j     <= j + MCNT_W'(1);
        found <= found || match;
      end
      if (cmd.rd_pop) begin
        pop_hi <= (h_fill != '0);
      end
      if (cmd.tick_add) begin
        credit <= (credit_sum > {1'b0, max_cr}) ? max_cr : credit_sum[CREDIT_W-1:0];
      end

      if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.append || cmd.pop_commit || cmd.emit_status) begin
        out_valid     <= 1'b1;
        out_kind      <= KIND_STATUS;
        out_port      <= '0;
        out_length    <= '0;
        out_byte0     <= '0;
        out_byte1     <= '0;
        out_byte2     <= '0;
        out_pending   <= any_pend;
        out_last      <= 1'b1;
        out_drained   <= '0;
        out_sent      <= sent;
        out_dropped   <= dropped;
        out_coalesced <= coal;
      end

      if (cmd.append) begin
        if ((op == OP_ENQ_HIGH) ? h_full : m_full) begin
          dropped     <= dropped + CNT_W'(1);
          out_dropped <= dropped + CNT_W'(1);
          out_kind    <= KIND_REFUSED;
          out_port    <= item_ent[39:32];
          out_length  <= item_ent[31:24];
        end else begin
          out_pending <= 1'b1;
          if (op == OP_ENQ_HIGH) begin
            h_fill <= h_fill + HCNT_W'(1);
          end else begin
            m_fill <= m_fill + MCNT_W'(1);
          end
        end
      end

      if (cmd.emit_status && op == OP_QUERY) begin
        out_pending <= found;
      end

      if (cmd.pop_commit) begin
        if (pop_hi) begin
          h_head <= hphys(h_head, HCNT_W'(1));
          h_fill <= h_fill - HCNT_W'(1);
        end else begin
          m_head <= mphys(m_head, MCNT_W'(1));
          m_fill <= m_fill - MCNT_W'(1);
        end
        if (op == OP_TICK) begin
          credit <= credit_m1[CREDIT_W-1:0];
        end
        drained     <= drained + DRAIN_W'(1);
        out_pending <= rem_after;
        out_last    <= sts.pop_last;
        out_drained <= (op == OP_DRAIN && sts.pop_last) ? drained + DRAIN_W'(1) : '0;
        out_port    <= pop_ent[39:32];
        out_length  <= p_len;
        if (len_ok) begin
          sent      <= sent + CNT_W'(1);
          out_sent  <= sent + CNT_W'(1);
          out_kind  <= KIND_SENT;
          out_byte0 <= pop_ent[23:16];
          out_byte1 <= (p_len > 8'd1) ? pop_ent[15:8] : 8'd0;
          out_byte2 <= (p_len > 8'd2) ? pop_ent[7:0] : 8'd0;
        end else begin
          dropped     <= dropped + CNT_W'(1);
          out_dropped <= dropped + CNT_W'(1);
          out_kind    <= KIND_DROPPED;
        end
      end
    end
  end

  a_main_fill: assert property (@(posedge clk) disable iff (rst)
    m_fill <= MAIN_FULL)
    else $error("main lane fill beyond depth");
  a_high_fill: assert property (@(posedge clk) disable iff (rst)
    h_fill <= HIGH_FULL)
    else $error("high lane fill beyond depth");
  a_compact: assert property (@(posedge clk) disable iff (rst)
    cmd.filt_eval |-> w <= j)
    else $error("compaction write pointer ahead of read pointer");
  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_drained != '0) |-> out_last)
    else $error("drained count on a result that is not last");
endmodule
`default_nettype wire

// ===== src/two_lane_credit_scheduler_unit.sv =====
`default_nettype none
// Two-lane credit scheduler. Messages wait in a high-priority FIFO and a main FIFO, both
// held in single-port-read RAMs as ring buffers. A tick adds budget_per_tick to a credit
// (capped at max_credit) and spends one whole credit per popped entry, high lane first;
// drain pops everything. Every result beat carries the running sent, dropped and coalesced
// totals, and last_flag marks the final beat of an item. An enqueue passes through accept,
// dispatch and append. Cancel and query walk the main lane with one RAM read and one
// evaluate per entry. Enqueue-position searches backward from the newest main entry; only
// when it finds a match does it compact the whole lane, again a read and an evaluate per
// entry, before the append. Tick and drain pass through dispatch, then a check and a
// commit step per popped entry. Any result stalled by the receiver holds the controller
// until it is taken. Each lane RAM has a single registered read port. No clearing pass
// is needed after reset.
module two_lane_credit_scheduler_unit import tlcs_pkg::*; #(
  parameter int MAIN_DEPTH       = MAIN_DEPTH_DEF,
  parameter int HIGH_DEPTH       = HIGH_DEPTH_DEF,
  parameter int CREDIT_FRAC_BITS = CREDIT_FRAC_BITS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  tlcs_item_if.sink      in_ch,
  tlcs_result_if.source  out_ch,
  tlcs_cfg_if.sink       cfg
);
  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  tlcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  tlcs_datapath #(
    .MAIN_DEPTH(MAIN_DEPTH), .HIGH_DEPTH(HIGH_DEPTH),
    .CREDIT_FRAC_BITS(CREDIT_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_operation(in_ch.operation), .in_param_id(in_ch.param_id),
    .in_has_param(in_ch.has_param), .in_out_port(in_ch.out_port),
    .in_msg_length(in_ch.msg_length), .in_msg_byte0(in_ch.msg_byte0),
    .in_msg_byte1(in_ch.msg_byte1), .in_msg_byte2(in_ch.msg_byte2),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_kind(out_ch.result_kind), .out_port(out_ch.sent_port),
    .out_length(out_ch.sent_length), .out_byte0(out_ch.sent_byte0),
    .out_byte1(out_ch.sent_byte1), .out_byte2(out_ch.sent_byte2),
    .out_pending(out_ch.pending_flag), .out_last(out_ch.last_flag),
    .out_drained(out_ch.drained_count), .out_sent(out_ch.sent_total),
    .out_dropped(out_ch.dropped_total), .out_coalesced(out_ch.coalesced_total)
  );
endmodule
`default_nettype wire
